// ===== rtl/core/oda_pkg.sv =====
// ----------------------------------------------------------------------------
// oda_pkg: shared types and constants for the odometry distance accumulator
// Field widths, register indexes, reset values, sequencer states and the
// status record of the square root unit.
// ----------------------------------------------------------------------------
package oda_pkg;

  // field and datapath widths
  localparam int VelW    = 32;
  localparam int SecW    = 8;
  localparam int PosW    = 32;
  localparam int AccW    = 48;
  localparam int CfgW    = 18;
  localparam int CfgAddrW = 2;
  localparam int MulAW   = 34;
  localparam int MulBW   = 18;
  localparam int MulPW   = MulAW + MulBW;
  localparam int RadW    = 66;
  localparam int RootW   = 34;

  // register indexes
  localparam logic [CfgAddrW-1:0] REG_VEL_DEADBAND   = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_LOSS_THRESHOLD = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_FIT_GAIN       = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_FIT_OFFSET     = 2'd3;

  // register reset values (0.01, 0.03, 1.0183, 0.0059)
  localparam logic [15:0] VEL_DEADBAND_RST   = 16'd655;
  localparam logic [15:0] LOSS_THRESHOLD_RST = 16'd1966;
  localparam logic [17:0] FIT_GAIN_RST       = 18'd66735;
  localparam logic [15:0] FIT_OFFSET_RST     = 16'd387;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VEL,
    ST_SQX0,
    ST_SQX1,
    ST_SQY0,
    ST_SQY1,
    ST_SQADD,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_MOVE,
    ST_FIT0,
    ST_FIT1,
    ST_FITSUM,
    ST_FITSAT,
    ST_DONE
  } state_t;

  // square root unit status
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// ===== rtl/core/odometry_distance_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// odometry_distance_accumulator_core: velocity and map distance integration
// A sample runs through the velocity product, the squared position step,
// the square root loop and, when the fit is formed, the fit; the loop dominates.
// One sample at a time: a new sample is taken only once the last is through.
// The result register lets the next sample in while a result waits.
// Synchronous active-low reset clears accumulators, kept position and
// restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module odometry_distance_accumulator_core (
  input  logic         clk,
  input  logic         rst_n,
  // slave side, tdata: linear_velocity[31:0], elapsed_seconds[39:32],
  // pos_x[71:40], pos_y[103:72]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,
  // master side, tdata: signed_displacement[47:0], travelled_distance[95:48],
  // map_distance_fit[143:96]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [17:0]  cfg_data
);

  localparam int AccW = oda_pkg::AccW;

  oda_pkg::state_t state_r, state_nxt;

  // configuration
  logic [15:0] vel_deadband_r;
  logic [15:0] loss_threshold_r;
  logic [17:0] fit_gain_r;
  logic [15:0] fit_offset_r;

  // sample
  logic signed [oda_pkg::VelW-1:0] vel_r;
  logic [oda_pkg::SecW-1:0]        sec_r;
  logic [oda_pkg::PosW-1:0]        px_r, py_r;

  // state
  logic [AccW-1:0]          disp_r, dist_r, map_dist_r, map_fit_r;
  logic [oda_pkg::PosW-1:0] kept_x_r, kept_y_r;
  logic                     first_r;
  logic [oda_pkg::PosW-1:0] ax_r, ay_r;
  logic [oda_pkg::RadW-1:0] acc_r;
  logic                     vel_neg_r;

  // result register
  logic              out_valid_r;
  logic [AccW*3-1:0] out_data_r;

  // shared units
  logic [oda_pkg::MulAW-1:0]  mul_a;
  logic [oda_pkg::MulBW-1:0]  mul_b;
  logic [oda_pkg::MulPW-1:0]  prod;
  logic                       sqrt_start;
  logic [oda_pkg::RootW-1:0]  root;
  oda_pkg::sqrt_stat_t        sqrt_stat;

  // datapath helpers
  logic [oda_pkg::VelW-1:0]   vel_abs;
  logic                       vel_zero;
  logic signed [32:0]         dx_diff, dy_diff;
  logic [32:0]                dx_mag, dy_mag;
  logic [39:0]                dmag;
  logic signed [40:0]         dsigned;
  logic signed [AccW:0]       disp_sum;
  logic [AccW:0]              dist_sum;
  logic [AccW:0]              map_sum;
  logic [AccW+2:0]            fit_sum;
  logic                       moved;

  oda_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  oda_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (acc_r),
    .root     (root),
    .stat     (sqrt_stat)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == oda_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // combinational datapath
  always_comb begin
    vel_abs  = vel_r[oda_pkg::VelW-1] ? (~vel_r + 1'b1) : vel_r;
    vel_zero = (vel_abs < oda_pkg::VelW'(vel_deadband_r));
    dx_diff  = $signed({px_r[31], px_r}) - $signed({kept_x_r[31], kept_x_r});
    dy_diff  = $signed({py_r[31], py_r}) - $signed({kept_y_r[31], kept_y_r});
    dx_mag   = dx_diff[32] ? (~dx_diff + 1'b1) : dx_diff;
    dy_mag   = dy_diff[32] ? (~dy_diff + 1'b1) : dy_diff;
    dmag     = prod[39:0];
    dsigned  = vel_neg_r ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    disp_sum = $signed({disp_r[AccW-1], disp_r}) + (AccW+1)'(dsigned);
    dist_sum = {1'b0, dist_r} + (AccW+1)'(dmag);
    map_sum  = {1'b0, map_dist_r} + (AccW+1)'(root);
    fit_sum  = {1'b0, acc_r[65:16]} + (AccW+3)'(fit_offset_r);
    moved    = (root > oda_pkg::RootW'(loss_threshold_r));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oda_pkg::ST_IDLE:      if (in_tvalid) state_nxt = oda_pkg::ST_VEL;
      oda_pkg::ST_VEL:       state_nxt = oda_pkg::ST_SQX0;
      oda_pkg::ST_SQX0:      state_nxt = oda_pkg::ST_SQX1;
      oda_pkg::ST_SQX1:      state_nxt = oda_pkg::ST_SQY0;
      oda_pkg::ST_SQY0:      state_nxt = oda_pkg::ST_SQY1;
      oda_pkg::ST_SQY1:      state_nxt = oda_pkg::ST_SQADD;
      oda_pkg::ST_SQADD:     state_nxt = oda_pkg::ST_ROOT_GO;
      oda_pkg::ST_ROOT_GO:   state_nxt = oda_pkg::ST_ROOT_WAIT;
      oda_pkg::ST_ROOT_WAIT: if (sqrt_stat.done) state_nxt = oda_pkg::ST_MOVE;
      oda_pkg::ST_MOVE: begin
        if (moved && !first_r) state_nxt = oda_pkg::ST_FIT0;
        else                   state_nxt = oda_pkg::ST_DONE;
      end
      oda_pkg::ST_FIT0:      state_nxt = oda_pkg::ST_FIT1;
      oda_pkg::ST_FIT1:      state_nxt = oda_pkg::ST_FITSUM;
      oda_pkg::ST_FITSUM:    state_nxt = oda_pkg::ST_FITSAT;
      oda_pkg::ST_FITSAT:    state_nxt = oda_pkg::ST_DONE;
      oda_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = oda_pkg::ST_IDLE;
      end
      default:               state_nxt = oda_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands and root start
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    unique case (state_r)
      oda_pkg::ST_VEL: begin
        mul_a = vel_zero ? '0 : oda_pkg::MulAW'(vel_abs);
        mul_b = oda_pkg::MulBW'(sec_r);
      end
      oda_pkg::ST_SQX0: begin
        mul_a = oda_pkg::MulAW'(ax_r);
        mul_b = oda_pkg::MulBW'(ax_r[15:0]);
      end
      oda_pkg::ST_SQX1: begin
        mul_a = oda_pkg::MulAW'(ax_r);
        mul_b = oda_pkg::MulBW'(ax_r[31:16]);
      end
      oda_pkg::ST_SQY0: begin
        mul_a = oda_pkg::MulAW'(ay_r);
        mul_b = oda_pkg::MulBW'(ay_r[15:0]);
      end
      oda_pkg::ST_SQY1: begin
        mul_a = oda_pkg::MulAW'(ay_r);
        mul_b = oda_pkg::MulBW'(ay_r[31:16]);
      end
      oda_pkg::ST_ROOT_GO: sqrt_start = 1'b1;
      oda_pkg::ST_FIT0: begin
        mul_a = map_dist_r[33:0];
        mul_b = fit_gain_r;
      end
      oda_pkg::ST_FIT1: begin
        mul_a = oda_pkg::MulAW'(map_dist_r[47:34]);
        mul_b = fit_gain_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= oda_pkg::ST_IDLE;
      out_valid_r      <= 1'b0;
      first_r          <= 1'b1;
      disp_r           <= '0;
      dist_r           <= '0;
      map_dist_r       <= '0;
      map_fit_r        <= '0;
      kept_x_r         <= '0;
      kept_y_r         <= '0;
      vel_deadband_r   <= oda_pkg::VEL_DEADBAND_RST;
      loss_threshold_r <= oda_pkg::LOSS_THRESHOLD_RST;
      fit_gain_r       <= oda_pkg::FIT_GAIN_RST;
      fit_offset_r     <= oda_pkg::FIT_OFFSET_RST;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_valid) begin
        unique case (cfg_addr)
          oda_pkg::REG_VEL_DEADBAND:   vel_deadband_r   <= cfg_data[15:0];
          oda_pkg::REG_LOSS_THRESHOLD: loss_threshold_r <= cfg_data[15:0];
          oda_pkg::REG_FIT_GAIN:       fit_gain_r       <= cfg_data;
          oda_pkg::REG_FIT_OFFSET:     fit_offset_r     <= cfg_data[15:0];
          default: ;
        endcase
      end

      // result register: load when finished, clear on transfer
      if (state_r == oda_pkg::ST_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        // velocity product is ready: update both travel accumulators
        oda_pkg::ST_SQX0: begin
          if (disp_sum[AccW] != disp_sum[AccW-1]) begin
            disp_r <= disp_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                     : {1'b0, {(AccW-1){1'b1}}};
          end else begin
            disp_r <= disp_sum[AccW-1:0];
          end
          dist_r <= dist_sum[AccW] ? {AccW{1'b1}} : dist_sum[AccW-1:0];
        end
        // movement check
        oda_pkg::ST_MOVE: begin
          if (moved) begin
            kept_x_r <= px_r;
            kept_y_r <= py_r;
            first_r  <= 1'b0;
            if (first_r) begin
              map_dist_r <= '0;
              map_fit_r  <= '0;
            end else begin
              map_dist_r <= map_sum[AccW] ? {AccW{1'b1}} : map_sum[AccW-1:0];
            end
          end
        end
        // offset and saturate the fit
        oda_pkg::ST_FITSAT: begin
          map_fit_r <= (fit_sum[AccW+2:AccW] != '0) ? {AccW{1'b1}}
                                                     : fit_sum[AccW-1:0];
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      oda_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          vel_r <= in_tdata[31:0];
          sec_r <= in_tdata[39:32];
          px_r  <= in_tdata[71:40];
          py_r  <= in_tdata[103:72];
        end
      end
      oda_pkg::ST_VEL: begin
        vel_neg_r <= vel_r[oda_pkg::VelW-1] && !vel_zero;
        ax_r      <= dx_mag[31:0];
        ay_r      <= dy_mag[31:0];
      end
      // sum of squares from partial products
      oda_pkg::ST_SQX1:  acc_r <= oda_pkg::RadW'(prod);
      oda_pkg::ST_SQY0:  acc_r <= acc_r + (oda_pkg::RadW'(prod) << 16);
      oda_pkg::ST_SQY1:  acc_r <= acc_r + oda_pkg::RadW'(prod);
      oda_pkg::ST_SQADD: acc_r <= acc_r + (oda_pkg::RadW'(prod) << 16);
      // gain times map distance from two partial products
      oda_pkg::ST_FIT1:   acc_r <= oda_pkg::RadW'(prod);
      oda_pkg::ST_FITSUM: acc_r <= acc_r + (oda_pkg::RadW'(prod) << 34);
      oda_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) out_data_r <= {map_fit_r, dist_r, disp_r};
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/oda_mul.sv =====
// ----------------------------------------------------------------------------
// oda_mul: shared unsigned multiplier
// One 34 x 18 bit product per cycle, registered. Wider products are built
// by the sequencer from several passes.
// ----------------------------------------------------------------------------
module oda_mul (
  input  logic                      clk,
  input  logic [oda_pkg::MulAW-1:0] op_a,
  input  logic [oda_pkg::MulBW-1:0] op_b,
  output logic [oda_pkg::MulPW-1:0] prod
);

  logic [oda_pkg::MulPW-1:0] prod_r;

  // registered product
  always_ff @(posedge clk) begin
    prod_r <= oda_pkg::MulPW'(op_a) * oda_pkg::MulPW'(op_b);
  end

  assign prod = prod_r;

endmodule

// ===== rtl/core/oda_sqrt.sv =====
// ----------------------------------------------------------------------------
// oda_sqrt: iterative truncating integer square root
// Restoring method, one root bit per cycle, a 34 bit root from a 66 bit radicand.
// ----------------------------------------------------------------------------
module oda_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [oda_pkg::RadW-1:0]   radicand,
  output logic [oda_pkg::RootW-1:0]  root,
  output oda_pkg::sqrt_stat_t        stat
);

  localparam int PadW = 2 * oda_pkg::RootW;
  localparam int RemW = oda_pkg::RootW + 3;
  localparam int CntW = $clog2(oda_pkg::RootW);

  logic [PadW-1:0]             rad_r, rad_nxt;
  logic [RemW-1:0]             rem_r, rem_nxt;
  logic [oda_pkg::RootW-1:0]   root_r, root_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [RemW-1:0]             rem_sh;
  logic [RemW-1:0]             trial;

  // one root bit per step
  always_comb begin
    rem_sh   = {rem_r[RemW-3:0], rad_r[PadW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = PadW'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CntW'(oda_pkg::RootW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[PadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[oda_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[oda_pkg::RootW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
